// File: rtl/quadratic_roots_six_permutations_assert.svh
// ----------------------------------------------------------------------------
// quadratic roots assertion macros
// shared forms for the concurrent checks on the result channel
// ----------------------------------------------------------------------------
`ifndef QUADRATIC_ROOTS_SIX_PERMUTATIONS_ASSERT_SVH
`define QUADRATIC_ROOTS_SIX_PERMUTATIONS_ASSERT_SVH

// condition holds in the same cycle
`define QRSP_ASSERT_NOW(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error(msg);

// condition holds in the following cycle
`define QRSP_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error(msg);

`endif

// File: rtl/qrsp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qrsp_pkg
// types, widths and tables shared by the quadratic roots block
// ----------------------------------------------------------------------------
package qrsp_pkg;

  localparam int COEF_WIDTH = 32;
  localparam int FRAC_BITS  = 16;
  localparam int TOL_WIDTH  = 31;
  localparam logic [TOL_WIDTH-1:0] TOL_RESET = TOL_WIDTH'(66);

  localparam int DISC_WIDTH = 2 * COEF_WIDTH + 1;
  localparam int EPS_WIDTH  = TOL_WIDTH + FRAC_BITS;
  localparam int CMP_WIDTH  = (DISC_WIDTH > EPS_WIDTH) ? DISC_WIDTH : EPS_WIDTH;
  localparam int NEAR_WIDTH = (COEF_WIDTH > TOL_WIDTH) ? COEF_WIDTH : TOL_WIDTH;
  localparam int SQRT_WIDTH = COEF_WIDTH + 1;
  localparam int NUM_WIDTH  = COEF_WIDTH + 2;
  localparam int DEN_WIDTH  = COEF_WIDTH + 1;
  localparam int QUO_WIDTH  = NUM_WIDTH + FRAC_BITS;

  localparam logic [2:0] PERM_FIRST = 3'd0;
  localparam logic [2:0] PERM_LAST  = 3'd5;

  typedef enum logic [1:0] {
    KIND_NONE,
    KIND_ONE,
    KIND_TWO,
    KIND_INF
  } root_kind_t;

  typedef enum logic {
    ST_OK,
    ST_TOL_ZERO
  } status_t;

  typedef enum logic [3:0] {
    SV_IDLE,
    SV_SETUP,
    SV_ROUTE,
    SV_MUL,
    SV_DISC,
    SV_CLASS,
    SV_SQRT,
    SV_ROOTS,
    SV_WAIT,
    SV_EMIT
  } solve_state_t;

  typedef struct packed {
    logic signed [COEF_WIDTH-1:0] coef_first;
    logic signed [COEF_WIDTH-1:0] coef_second;
    logic signed [COEF_WIDTH-1:0] coef_third;
  } coef_item_t;

  typedef struct packed {
    status_t                      status;
    logic [2:0]                   perm_index;
    root_kind_t                   root_kind;
    logic signed [COEF_WIDTH-1:0] quad_coef;
    logic signed [COEF_WIDTH-1:0] lin_coef;
    logic signed [COEF_WIDTH-1:0] const_coef;
    logic signed [COEF_WIDTH-1:0] root_one;
    logic signed [COEF_WIDTH-1:0] root_two;
    logic                         last;
  } root_item_t;

  typedef struct packed {
    logic [2:0][COEF_WIDTH-1:0] raw;
    logic [2:0][COEF_WIDTH-1:0] mag;
    logic [2:0]                 neg;
    logic [2:0]                 near;
    logic                       tol_zero;
    logic [TOL_WIDTH-1:0]       tol;
  } work_t;

  typedef struct packed {
    logic                 start;
    logic                 neg;
    logic [NUM_WIDTH-1:0] num;
    logic [DEN_WIDTH-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic                         done;
    logic signed [COEF_WIDTH-1:0] root;
  } div_rsp_t;

  function automatic logic [1:0] perm_pick(input logic [2:0] k, input logic [1:0] slot);
    logic [5:0] row;
    logic [1:0] pick;
    case (k)
      3'd0:    row = {2'd2, 2'd1, 2'd0};
      3'd1:    row = {2'd1, 2'd2, 2'd0};
      3'd2:    row = {2'd2, 2'd0, 2'd1};
      3'd3:    row = {2'd0, 2'd2, 2'd1};
      3'd4:    row = {2'd1, 2'd0, 2'd2};
      3'd5:    row = {2'd0, 2'd1, 2'd2};
      default: row = {2'd2, 2'd1, 2'd0};
    endcase
    case (slot)
      2'd0:    pick = row[1:0];
      2'd1:    pick = row[3:2];
      default: pick = row[5:4];
    endcase
    return pick;
  endfunction

endpackage

// File: rtl/qrsp_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qrsp_queue
// two-entry queue between the front and the solver
// ----------------------------------------------------------------------------
module qrsp_queue #(
  parameter type item_t = logic
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  item_t push_item,
  output logic  full,
  input  logic  pop,
  output item_t pop_item,
  output logic  empty
);

  item_t      slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

  assign full     = (count == 2'd2);
  assign empty    = (count == 2'd0);
  assign pop_item = slots[rd_ptr];

endmodule

// File: rtl/qrsp_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qrsp_front
// tolerance register, item intake and near-zero classification
// ----------------------------------------------------------------------------
module qrsp_front
  import qrsp_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 coef_valid,
  output logic                 coef_ready,
  input  coef_item_t           coef_data,
  input  logic                 tol_we,
  input  logic [TOL_WIDTH-1:0] tol_wdata,
  output logic                 push,
  output work_t                push_item,
  input  logic                 full
);

  logic [TOL_WIDTH-1:0]       tol;
  logic [2:0][COEF_WIDTH-1:0] raw;
  logic [2:0][COEF_WIDTH-1:0] mag;
  logic [2:0]                 neg;
  logic [2:0]                 near;

  always_ff @(posedge clk) begin
    if (rst) begin
      tol <= TOL_RESET;
    end else if (tol_we) begin
      tol <= tol_wdata;
    end
  end

  always_comb begin
    raw[0] = coef_data.coef_first;
    raw[1] = coef_data.coef_second;
    raw[2] = coef_data.coef_third;
    for (int i = 0; i < 3; i++) begin
      neg[i]  = raw[i][COEF_WIDTH-1];
      mag[i]  = neg[i] ? (~raw[i] + COEF_WIDTH'(1)) : raw[i];
      near[i] = NEAR_WIDTH'(mag[i]) < NEAR_WIDTH'(tol);
    end
  end

  assign coef_ready = !full;
  assign push       = coef_valid && !full;

  always_comb begin
    push_item.raw      = raw;
    push_item.mag      = mag;
    push_item.neg      = neg;
    push_item.near     = near;
    push_item.tol_zero = (tol == '0);
    push_item.tol      = tol;
  end

endmodule

// File: rtl/qrsp_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qrsp_div
// bit-serial fixed-point divider with sign and saturation
// ----------------------------------------------------------------------------
module qrsp_div
  import qrsp_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  localparam int CNT_WIDTH = $clog2(QUO_WIDTH + 1);

  logic                 busy;
  logic                 done;
  logic [CNT_WIDTH-1:0] cnt;
  logic [QUO_WIDTH-1:0] dvd;
  logic [QUO_WIDTH-1:0] quo;
  logic [DEN_WIDTH-1:0] rem;
  logic [DEN_WIDTH-1:0] den;
  logic                 neg;
  logic [DEN_WIDTH:0]   trial;
  logic [DEN_WIDTH:0]   diff;
  logic [QUO_WIDTH-1:0] lim;
  logic [QUO_WIDTH-1:0] mag_sat;
  logic [COEF_WIDTH-1:0] mag_w;

  assign trial = {rem, dvd[QUO_WIDTH-1]};
  assign diff  = trial - {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= CNT_WIDTH'(QUO_WIDTH);
      end else if (busy) begin
        cnt <= cnt - CNT_WIDTH'(1);
        if (cnt == CNT_WIDTH'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      dvd <= {req.num, {FRAC_BITS{1'b0}}};
      quo <= '0;
      rem <= '0;
      den <= req.den;
      neg <= req.neg;
    end else if (busy) begin
      dvd <= dvd << 1;
      if (!diff[DEN_WIDTH]) begin
        rem <= diff[DEN_WIDTH-1:0];
        quo <= {quo[QUO_WIDTH-2:0], 1'b1};
      end else begin
        rem <= trial[DEN_WIDTH-1:0];
        quo <= {quo[QUO_WIDTH-2:0], 1'b0};
      end
    end
  end

  always_comb begin
    lim     = (QUO_WIDTH'(1) << (COEF_WIDTH - 1)) - (neg ? QUO_WIDTH'(0) : QUO_WIDTH'(1));
    mag_sat = (quo > lim) ? lim : quo;
    mag_w   = mag_sat[COEF_WIDTH-1:0];
  end

  assign rsp.done = done;
  assign rsp.root = neg ? -mag_w : mag_w;

endmodule

// File: rtl/qrsp_solve.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qrsp_solve
// per-ordering sequencer: multiply, discriminant, square root, divide, emit
// ----------------------------------------------------------------------------
module qrsp_solve
  import qrsp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  work_t      pop_item,
  input  logic       empty,
  output logic       pop,
  output logic       res_valid,
  input  logic       res_ready,
  output root_item_t res_data,
  output div_req_t   div0_req,
  output div_req_t   div1_req,
  input  div_rsp_t   div0_rsp,
  input  div_rsp_t   div1_rsp
);

  localparam int CNT_WIDTH = $clog2(SQRT_WIDTH + 1);
  localparam int PW = 2 * COEF_WIDTH;
  localparam int SQW = 2 * SQRT_WIDTH;

  solve_state_t state, state_next;

  logic [2:0]            perm;
  logic [COEF_WIDTH-1:0] ma, mb, mc;
  logic                  na, nb, nc;
  logic                  near_a, near_b, near_c;
  logic [COEF_WIDTH-1:0] raw_a, raw_b, raw_c;
  logic [PW-1:0]         mcand_b, mcand_ac, acc_b, acc_ac;
  logic [COEF_WIDTH-1:0] mplier_b, mplier_ac;
  logic [CNT_WIDTH-1:0]  cnt;
  logic [DISC_WIDTH-1:0] d;
  logic                  dneg;
  logic [SQW-1:0]        sq_op, sq_res, sq_one, sq_sum;
  logic                  sq_ge;
  root_kind_t            kind;
  logic                  single;
  logic [COEF_WIDTH-1:0] r1, r2;

  logic                  out_free;
  logic                  load;
  logic                  is_last;
  logic [1:0]            ia, ib, ic;
  logic [DISC_WIDTH-1:0] b2, p4;
  logic [CMP_WIDTH-1:0]  eps;
  logic                  d_small;
  logic [NUM_WIDTH-1:0]  nbn, n1, n2, mag1, mag2;

  assign out_free = !res_valid || res_ready;
  assign is_last  = pop_item.tol_zero || (perm == PERM_LAST);
  assign ia       = perm_pick(perm, 2'd0);
  assign ib       = perm_pick(perm, 2'd1);
  assign ic       = perm_pick(perm, 2'd2);

  always_comb begin
    b2      = DISC_WIDTH'(acc_b);
    p4      = DISC_WIDTH'(acc_ac) << 2;
    eps     = CMP_WIDTH'(pop_item.tol) << FRAC_BITS;
    d_small = CMP_WIDTH'(d) < eps;
    sq_sum  = sq_res + sq_one;
    sq_ge   = sq_op >= sq_sum;
    nbn     = nb ? NUM_WIDTH'(mb) : -NUM_WIDTH'(mb);
    n1      = nbn + NUM_WIDTH'(sq_res[SQRT_WIDTH-1:0]);
    n2      = nbn - NUM_WIDTH'(sq_res[SQRT_WIDTH-1:0]);
    mag1    = n1[NUM_WIDTH-1] ? -n1 : n1;
    mag2    = n2[NUM_WIDTH-1] ? -n2 : n2;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= SV_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    pop        = 1'b0;
    load       = 1'b0;
    div0_req   = '0;
    div1_req   = '0;
    case (state)
      SV_IDLE: begin
        if (!empty) begin
          state_next = SV_SETUP;
        end
      end
      SV_SETUP: begin
        state_next = pop_item.tol_zero ? SV_EMIT : SV_ROUTE;
      end
      SV_ROUTE: begin
        if (near_a) begin
          if (near_b) begin
            state_next = SV_EMIT;
          end else begin
            div0_req.start = 1'b1;
            div0_req.num   = NUM_WIDTH'(mc);
            div0_req.neg   = !nc ^ nb;
            div0_req.den   = DEN_WIDTH'(mb);
            state_next     = SV_WAIT;
          end
        end else begin
          state_next = SV_MUL;
        end
      end
      SV_MUL: begin
        if (cnt == CNT_WIDTH'(1)) begin
          state_next = SV_DISC;
        end
      end
      SV_DISC: begin
        state_next = SV_CLASS;
      end
      SV_CLASS: begin
        if (dneg && !d_small) begin
          state_next = SV_EMIT;
        end else if (d_small) begin
          div0_req.start = 1'b1;
          div0_req.num   = NUM_WIDTH'(mb);
          div0_req.neg   = !nb ^ na;
          div0_req.den   = {ma, 1'b0};
          state_next     = SV_WAIT;
        end else begin
          state_next = SV_SQRT;
        end
      end
      SV_SQRT: begin
        if (cnt == CNT_WIDTH'(1)) begin
          state_next = SV_ROOTS;
        end
      end
      SV_ROOTS: begin
        div0_req.start = 1'b1;
        div0_req.num   = mag1;
        div0_req.neg   = n1[NUM_WIDTH-1] ^ na;
        div0_req.den   = {ma, 1'b0};
        div1_req.start = 1'b1;
        div1_req.num   = mag2;
        div1_req.neg   = n2[NUM_WIDTH-1] ^ na;
        div1_req.den   = {ma, 1'b0};
        state_next     = SV_WAIT;
      end
      SV_WAIT: begin
        if (div0_rsp.done) begin
          state_next = SV_EMIT;
        end
      end
      SV_EMIT: begin
        if (out_free) begin
          load = 1'b1;
          if (is_last) begin
            pop        = 1'b1;
            state_next = SV_IDLE;
          end else begin
            state_next = SV_SETUP;
          end
        end
      end
      default: begin
        state_next = SV_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    case (state)
      SV_IDLE: begin
        perm <= PERM_FIRST;
      end
      SV_SETUP: begin
        ma     <= pop_item.mag[ia];
        mb     <= pop_item.mag[ib];
        mc     <= pop_item.mag[ic];
        na     <= pop_item.neg[ia];
        nb     <= pop_item.neg[ib];
        nc     <= pop_item.neg[ic];
        near_a <= pop_item.near[ia];
        near_b <= pop_item.near[ib];
        near_c <= pop_item.near[ic];
        raw_a  <= pop_item.raw[ia];
        raw_b  <= pop_item.raw[ib];
        raw_c  <= pop_item.raw[ic];
        kind   <= KIND_NONE;
        single <= 1'b1;
        r1     <= '0;
        r2     <= '0;
      end
      SV_ROUTE: begin
        if (near_a) begin
          if (near_b) begin
            kind <= near_c ? KIND_INF : KIND_NONE;
          end else begin
            kind <= KIND_ONE;
          end
        end
        mcand_b   <= PW'(mb);
        mplier_b  <= mb;
        acc_b     <= '0;
        mcand_ac  <= PW'(ma);
        mplier_ac <= mc;
        acc_ac    <= '0;
        cnt       <= CNT_WIDTH'(COEF_WIDTH);
      end
      SV_MUL: begin
        if (mplier_b[0]) begin
          acc_b <= acc_b + mcand_b;
        end
        if (mplier_ac[0]) begin
          acc_ac <= acc_ac + mcand_ac;
        end
        mcand_b   <= mcand_b << 1;
        mcand_ac  <= mcand_ac << 1;
        mplier_b  <= mplier_b >> 1;
        mplier_ac <= mplier_ac >> 1;
        cnt       <= cnt - CNT_WIDTH'(1);
      end
      SV_DISC: begin
        if (na != nc) begin
          d    <= b2 + p4;
          dneg <= 1'b0;
        end else if (b2 >= p4) begin
          d    <= b2 - p4;
          dneg <= 1'b0;
        end else begin
          d    <= p4 - b2;
          dneg <= 1'b1;
        end
      end
      SV_CLASS: begin
        if (dneg && !d_small) begin
          kind <= KIND_NONE;
        end else if (d_small) begin
          kind <= KIND_ONE;
        end else begin
          kind <= KIND_TWO;
          single <= 1'b0;
        end
        sq_op  <= SQW'(d);
        sq_res <= '0;
        sq_one <= SQW'(1) << (SQW - 2);
        cnt    <= CNT_WIDTH'(SQRT_WIDTH);
      end
      SV_SQRT: begin
        if (sq_ge) begin
          sq_op  <= sq_op - sq_sum;
          sq_res <= (sq_res >> 1) + sq_one;
        end else begin
          sq_res <= sq_res >> 1;
        end
        sq_one <= sq_one >> 2;
        cnt    <= cnt - CNT_WIDTH'(1);
      end
      SV_WAIT: begin
        if (div0_rsp.done) begin
          r1 <= div0_rsp.root;
          r2 <= single ? div0_rsp.root : div1_rsp.root;
        end
      end
      SV_EMIT: begin
        if (load && !is_last) begin
          perm <= perm + 3'd1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (load) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_data.status     <= pop_item.tol_zero ? ST_TOL_ZERO : ST_OK;
      res_data.perm_index <= pop_item.tol_zero ? PERM_FIRST : perm;
      res_data.root_kind  <= kind;
      res_data.quad_coef  <= raw_a;
      res_data.lin_coef   <= raw_b;
      res_data.const_coef <= raw_c;
      res_data.root_one   <= r1;
      res_data.root_two   <= r2;
      res_data.last       <= is_last;
    end
  end

endmodule

// File: rtl/quadratic_roots_six_permutations.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quadratic_roots_six_permutations
// Each item of three Q16.16 coefficients yields six result items, one per
// ordering (a,b,c), or a single error item when the tolerance is zero. The
// front takes an item whenever its two-entry queue has room; the solver works
// through the orderings one at a time. An ordering is settled by the near-zero
// tests alone, by one divider for a linear root, by the bit-serial b*b and a*c
// multipliers for no roots, by the multipliers and one divider for a double
// root, and for two roots by the multipliers, the digit-by-digit square root
// and the two dividers, which run side by side. The solver returns to idle
// between items, and the result channel can stall it before each result item
// is emitted. The tolerance register may only be written while idle.
// ----------------------------------------------------------------------------
module quadratic_roots_six_permutations
  import qrsp_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 coef_valid,
  output logic                 coef_ready,
  input  coef_item_t           coef_data,
  output logic                 res_valid,
  input  logic                 res_ready,
  output root_item_t           res_data,
  input  logic                 tol_we,
  input  logic [TOL_WIDTH-1:0] tol_wdata
);

  logic     push;
  work_t    push_item;
  logic     full;
  logic     pop;
  work_t    pop_item;
  logic     empty;
  div_req_t div0_req, div1_req;
  div_rsp_t div0_rsp, div1_rsp;

  qrsp_front u_front (
    .clk        (clk),
    .rst        (rst),
    .coef_valid (coef_valid),
    .coef_ready (coef_ready),
    .coef_data  (coef_data),
    .tol_we     (tol_we),
    .tol_wdata  (tol_wdata),
    .push       (push),
    .push_item  (push_item),
    .full       (full)
  );

  qrsp_queue #(
    .item_t (work_t)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (full),
    .pop       (pop),
    .pop_item  (pop_item),
    .empty     (empty)
  );

  qrsp_solve u_solve (
    .clk       (clk),
    .rst       (rst),
    .pop_item  (pop_item),
    .empty     (empty),
    .pop       (pop),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_data  (res_data),
    .div0_req  (div0_req),
    .div1_req  (div1_req),
    .div0_rsp  (div0_rsp),
    .div1_rsp  (div1_rsp)
  );

  qrsp_div u_div0 (
    .clk (clk),
    .rst (rst),
    .req (div0_req),
    .rsp (div0_rsp)
  );

  qrsp_div u_div1 (
    .clk (clk),
    .rst (rst),
    .req (div1_req),
    .rsp (div1_rsp)
  );

endmodule

// File: rtl/qrsp_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qrsp_checker
// port-level checks on the result channel, bound to the top level
// ----------------------------------------------------------------------------
`include "quadratic_roots_six_permutations_assert.svh"

module qrsp_checker
  import qrsp_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       res_valid,
  input logic       res_ready,
  input root_item_t res_data
);

  `QRSP_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(res_data), "result item changed while stalled")
  `QRSP_ASSERT_NOW(a_err_last, res_valid && (res_data.status == ST_TOL_ZERO), res_data.last, "error item not marked last")
  `QRSP_ASSERT_NOW(a_one_root, res_valid && (res_data.root_kind != KIND_TWO), res_data.root_one == res_data.root_two, "roots differ without two roots")
  `QRSP_ASSERT_NOW(a_no_root, res_valid && (res_data.root_kind == KIND_NONE || res_data.root_kind == KIND_INF), res_data.root_one == '0, "root set where none exists")
  `QRSP_ASSERT_NOW(a_last_perm, res_valid && res_data.last && (res_data.status == ST_OK), res_data.perm_index == PERM_LAST, "run ended before final ordering")

endmodule

bind quadratic_roots_six_permutations qrsp_checker u_checker (.*);
